/* rtl/core/mvc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mvc_pkg
// Shared types, register map constants and per-function vector layout for
// the message-signalled interrupt controller.
// ----------------------------------------------------------------------------
package mvc_pkg;

  // Fixed field widths.
  localparam int DATA_W    = 32;
  localparam int OFS_W     = 12;
  localparam int FUNC_W    = 3;
  localparam int SUB_W     = 5;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int NUM_FUNCS = 8;

  // Default size of the low data word table.
  localparam int LOW_TABLE_WORDS_DEF = 52;

  // Width of a table index built from a function base plus a subfunction.
  localparam int TIDX_W = 7;

  // Register map.
  localparam logic [OFS_W-1:0] OFS_MASK_BASE  = 12'h04C;
  localparam logic [OFS_W-1:0] OFS_DATA_BASE  = 12'h08C;
  localparam logic [OFS_W-1:0] OFS_ADDR_BASE  = 12'h0AC;
  localparam logic [OFS_W-1:0] OFS_TABLE_BASE = 12'h100;
  localparam logic [OFS_W-1:0] CTL_SPAN       = OFS_W'(4 * NUM_FUNCS);

  // Highest subfunction number a trigger may name.
  localparam logic [SUB_W-1:0] MAX_SUB = 5'd30;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TRIG  = 2'd2
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_SUB_RANGE = 2'd1,
    ST_MASKED    = 2'd2,
    ST_SUB_COUNT = 2'd3
  } status_t;

  // First table word of each function.
  function automatic logic [TIDX_W-1:0] func_table_base(input logic [FUNC_W-1:0] f);
    logic [TIDX_W-1:0] b;
    case (f)
      3'd0:    b = 7'd0;
      3'd1:    b = 7'd4;
      3'd2:    b = 7'd8;
      3'd3:    b = 7'd12;
      3'd4:    b = 7'd16;
      3'd5:    b = 7'd40;
      3'd6:    b = 7'd44;
      3'd7:    b = 7'd48;
      default: b = 7'd0;
    endcase
    return b;
  endfunction

  // Number of vectors of each function.
  function automatic logic [SUB_W-1:0] func_vec_count(input logic [FUNC_W-1:0] f);
    logic [SUB_W-1:0] c;
    case (f)
      3'd4:    c = 5'd24;
      3'd5:    c = 5'd2;
      3'd6:    c = 5'd2;
      default: c = 5'd4;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/mvc_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mvc_req_if / mvc_rsp_if
// Valid/ready channels for requests into and results out of the interrupt
// controller.
// ----------------------------------------------------------------------------
interface mvc_req_if
  import mvc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [OFS_W-1:0]    offset;
  logic [DATA_W-1:0]   wr_data;
  logic [FUNC_W-1:0]   func_index;
  logic [SUB_W-1:0]    sub_index;

  modport source (output valid, kind, offset, wr_data, func_index, sub_index,
                  input ready);
  modport sink   (input valid, kind, offset, wr_data, func_index, sub_index,
                  output ready);
endinterface

interface mvc_rsp_if
  import mvc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   rd_data;
  logic                msi_valid;
  logic [DATA_W-1:0]   msi_addr;
  logic [DATA_W-1:0]   msi_data;
  logic [STATUS_W-1:0] status;

  modport source (output valid, rd_data, msi_valid, msi_addr, msi_data, status,
                  input ready);
  modport sink   (input valid, rd_data, msi_valid, msi_addr, msi_data, status,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/msi_vector_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// msi_vector_controller
// Message-signalled interrupt controller for eight functions: register
// reads and writes plus trigger requests that issue at most one message write.
// ----------------------------------------------------------------------------
//
//   Channel  Port    Direction  Moves
//   -------  ------  ---------  -------------------------------------------
//   request  in_ch   sink       kind, offset, wr_data, func_index, sub_index
//   result   out_ch  source     rd_data, msi_valid, msi_addr, msi_data, status
//
// One item is accepted per cycle unless both stages are full and the result
// waits; its result passes through the stage one registers and then the output
// register. Stage one reads the control registers and the table memory
// (registered read port); stage two forms the result into the output register.
// Reset clears the control registers and the table valid bits at once; there is
// no clearing pass. A stalled result holds the output register while one more item may enter stage one.
// ----------------------------------------------------------------------------
module msi_vector_controller
  import mvc_pkg::*;
#(
  parameter int LOW_TABLE_WORDS = LOW_TABLE_WORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mvc_req_if.sink    in_ch,
  mvc_rsp_if.source  out_ch
);

  localparam int TBL_AW = $clog2(LOW_TABLE_WORDS);
  localparam int TW_W   = OFS_W - 2;

  // Control registers and table storage.
  logic [DATA_W-1:0] enable_mask_r    [NUM_FUNCS];
  logic [DATA_W-1:0] base_data_r      [NUM_FUNCS];
  logic [DATA_W-1:0] target_address_r [NUM_FUNCS];
  logic [DATA_W-1:0] tbl_mem [LOW_TABLE_WORDS];
  logic [LOW_TABLE_WORDS-1:0] tbl_vld_r;

  // Handshake.
  logic s1_v_r, out_v_r;
  logic adv, acc;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv;
  assign acc         = in_ch.valid && in_ch.ready;

  // Request decode.
  kind_t             kind;
  logic [OFS_W-1:0]  m_rel, d_rel, a_rel, t_rel;
  logic              m_hit, d_hit, a_hit, t_hit;
  logic [FUNC_W-1:0] m_idx, d_idx, a_idx;
  logic [TW_W-1:0]   t_word;
  logic [TIDX_W-1:0] trig_idx;
  logic              trig_in;
  logic              is_trig, is_read, is_write;

  assign kind     = kind_t'(in_ch.kind);
  assign is_trig  = (kind == KIND_TRIG);
  assign is_read  = (kind == KIND_READ);
  assign is_write = (kind == KIND_WRITE);

  assign m_rel = in_ch.offset - OFS_MASK_BASE;
  assign d_rel = in_ch.offset - OFS_DATA_BASE;
  assign a_rel = in_ch.offset - OFS_ADDR_BASE;
  assign t_rel = in_ch.offset - OFS_TABLE_BASE;

  assign m_hit = (in_ch.offset >= OFS_MASK_BASE) && (m_rel < CTL_SPAN) && (m_rel[1:0] == 2'd0);
  assign d_hit = (in_ch.offset >= OFS_DATA_BASE) && (d_rel < CTL_SPAN) && (d_rel[1:0] == 2'd0);
  assign a_hit = (in_ch.offset >= OFS_ADDR_BASE) && (a_rel < CTL_SPAN) && (a_rel[1:0] == 2'd0);

  assign m_idx = m_rel[FUNC_W+1:2];
  assign d_idx = d_rel[FUNC_W+1:2];
  assign a_idx = a_rel[FUNC_W+1:2];

  // Table offsets ignore the two low bits.
  assign t_word = t_rel[OFS_W-1:2];
  assign t_hit  = (in_ch.offset >= OFS_TABLE_BASE) && (t_word < TW_W'(LOW_TABLE_WORDS));

  assign trig_idx = func_table_base(in_ch.func_index) + TIDX_W'(in_ch.sub_index);
  assign trig_in  = (trig_idx < TIDX_W'(LOW_TABLE_WORDS));

  // One read address per control array: the function on a trigger,
  // the decoded offset otherwise.
  logic [FUNC_W-1:0] m_sel, d_sel, a_sel;
  logic [DATA_W-1:0] mask_rd, base_rd, addr_rd, ctl_rd;

  assign m_sel   = is_trig ? in_ch.func_index : m_idx;
  assign d_sel   = is_trig ? in_ch.func_index : d_idx;
  assign a_sel   = is_trig ? in_ch.func_index : a_idx;
  assign mask_rd = enable_mask_r[m_sel];
  assign base_rd = base_data_r[d_sel];
  assign addr_rd = target_address_r[a_sel];

  always_comb begin
    ctl_rd = '0;
    if (is_read) begin
      if (m_hit)      ctl_rd = mask_rd;
      else if (d_hit) ctl_rd = base_rd;
      else if (a_hit) ctl_rd = addr_rd;
    end
  end

  // Control register writes, taken when the item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FUNCS; i++) begin
        enable_mask_r[i]    <= '0;
        base_data_r[i]      <= '0;
        target_address_r[i] <= '0;
      end
    end else if (acc && is_write) begin
      if (m_hit) enable_mask_r[m_idx]    <= in_ch.wr_data;
      if (d_hit) base_data_r[d_idx]      <= in_ch.wr_data;
      if (a_hit) target_address_r[a_idx] <= in_ch.wr_data;
    end
  end

  // Table memory: a write on an accepted write and a registered read on every accepted item.
  logic [TBL_AW-1:0] tbl_ra, tbl_wa;
  logic              tbl_rd_ok, tbl_we;
  logic [DATA_W-1:0] tbl_q_r;
  logic              tbl_ok_r;

  assign tbl_ra    = is_trig ? trig_idx[TBL_AW-1:0] : t_word[TBL_AW-1:0];
  assign tbl_rd_ok = is_trig ? trig_in : (is_read && t_hit);
  assign tbl_wa    = t_word[TBL_AW-1:0];
  assign tbl_we    = acc && is_write && t_hit;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= in_ch.wr_data;
    if (acc)    tbl_q_r         <= tbl_mem[tbl_ra];
  end

  // Valid bits stand in for the zero reset of the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (tbl_we) begin
      tbl_vld_r[tbl_wa] <= 1'b1;
    end
  end

  // Stage one registers.
  kind_t             s1_kind_r;
  logic [FUNC_W-1:0] s1_fn_r;
  logic [SUB_W-1:0]  s1_sub_r;
  logic [DATA_W-1:0] s1_ctl_rd_r, s1_mask_r, s1_base_r, s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r   <= kind;
      s1_fn_r     <= in_ch.func_index;
      s1_sub_r    <= in_ch.sub_index;
      s1_ctl_rd_r <= ctl_rd;
      s1_mask_r   <= mask_rd;
      s1_base_r   <= base_rd;
      s1_addr_r   <= addr_rd;
      tbl_ok_r    <= tbl_rd_ok && tbl_vld_r[tbl_ra];
    end
  end

  // Stage two: form the result.
  logic [DATA_W-1:0] tword;
  logic [DATA_W-1:0] rd_nxt, addr_nxt, data_nxt;
  logic              mv_nxt;
  status_t           st_nxt;

  assign tword = tbl_ok_r ? tbl_q_r : '0;

  always_comb begin
    rd_nxt   = '0;
    mv_nxt   = 1'b0;
    addr_nxt = '0;
    data_nxt = '0;
    st_nxt   = ST_OK;
    case (s1_kind_r)
      KIND_READ: begin
        rd_nxt = s1_ctl_rd_r | tword;
      end
      KIND_WRITE: begin
        rd_nxt = '0;
      end
      KIND_TRIG: begin
        if (s1_sub_r > MAX_SUB) begin
          st_nxt = ST_SUB_RANGE;
        end else if (!s1_mask_r[s1_sub_r]) begin
          st_nxt = ST_MASKED;
        end else if (s1_sub_r >= func_vec_count(s1_fn_r)) begin
          st_nxt = ST_SUB_COUNT;
        end else begin
          mv_nxt   = 1'b1;
          addr_nxt = s1_addr_r;
          data_nxt = s1_base_r | tword;
        end
      end
      default: begin
        rd_nxt = '0;
      end
    endcase
  end

  // Output register.
  logic [DATA_W-1:0] out_rd_r, out_addr_r, out_data_r;
  logic              out_mv_r;
  status_t           out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_rd_r   <= rd_nxt;
      out_mv_r   <= mv_nxt;
      out_addr_r <= addr_nxt;
      out_data_r <= data_nxt;
      out_st_r   <= st_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.rd_data   = out_rd_r;
  assign out_ch.msi_valid = out_mv_r;
  assign out_ch.msi_addr  = out_addr_r;
  assign out_ch.msi_data  = out_data_r;
  assign out_ch.status    = out_st_r;

`ifndef SYNTH
  // The request side only stalls when both stages are full and the result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && out_v_r && !out_ch.ready))
    else $error("request stalled without a full pipeline");

  // An item in stage one reaches the output register when the pipeline moves.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && adv) |=> out_v_r)
    else $error("stage one item lost");

  // A rejected trigger issues no message.
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_ch.status != ST_OK)) |->
      (!out_ch.msi_valid && (out_ch.msi_addr == '0) && (out_ch.msi_data == '0)))
    else $error("message issued on a rejected trigger");
`endif

endmodule
`default_nettype wire
